// ----- hw/rtl/tla_pkg.sv -----
// Shared types and constants for the text line assembler.
// No dependencies; imported by the store, the top level and the checker.
`timescale 1ns / 1ps

package tla_pkg;

   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   localparam logic STATUS_READY    = 1'b0;
   localparam logic STATUS_TOO_LONG = 1'b1;

   localparam logic [8:0] MAX_OUT_LEN_RESET = 9'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHAR,
      ST_LONE
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

// ----- hw/rtl/tla_store.sv -----
// Line store: single-port-write, registered-read character memory.
// Depends on tla_pkg for the control struct.
`timescale 1ns / 1ps

module tla_store
   import tla_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  store_ctl_type            ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [6:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [6:0]               rd_data
);

   logic [6:0] mem [DEPTH];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/text_line_assembler.sv -----
// Text line assembler: collects printable bytes into a line and replays the line
// on a terminator. Request bytes are accepted only while idle, not during a replay.
// Each character of a replay is first read from the single registered read port of
// the line store (ST_READ), then shown (ST_CHAR). A too-long or cut-to-nothing
// result is a single item without a character. Synchronous reset returns to idle,
// clears the length, the overflow flag and sets max_out_len to 64; the store itself is not cleared.
`timescale 1ns / 1ps

module text_line_assembler
   import tla_pkg::*;
#(
   parameter int unsigned LINE_CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] line_char, [7] zero
   output logic [1:0] rsp_tuser,   // [0] line_status, [1] char_valid
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_data     // [8:0] max_out_len
);

   localparam int unsigned LW = $clog2(LINE_CAPACITY);
   localparam logic [LW:0] CAP_W = LINE_CAPACITY[LW:0];

   state_type     state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic          status_ff, status_in;
   logic [8:0]    max_ff;

   store_ctl_type store_ctl;
   logic [6:0]    rd_data;

   logic          is_term;
   logic          is_print;
   logic          full;
   logic [8:0]    limit;
   logic [8:0]    len_wide;
   logic [8:0]    n_wide;
   logic [LW-1:0] n_line;
   logic          at_last;

   assign csr_ready = 1'b1;

   always_comb begin
      is_term  = (req_tdata == CHAR_LF) || (req_tdata == CHAR_CR);
      is_print = req_tdata inside {[PRINT_LO:PRINT_HI]};
      full     = ({1'b0, len_ff} + {{LW{1'b0}}, 1'b1}) >= CAP_W;
      limit    = (max_ff == 9'd0) ? 9'd0 : max_ff - 9'd1;
      len_wide = 9'(len_ff);
      n_wide   = (len_wide < limit) ? len_wide : limit;
      n_line   = n_wide[LW-1:0];
      at_last  = (idx_ff == (cnt_ff - {{(LW-1){1'b0}}, 1'b1}));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && is_term) begin
               if (ovf_ff) begin
                  state_in = ST_LONE;
               end else if (len_ff != '0) begin
                  state_in = (n_line == '0) ? ST_LONE : ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_CHAR;
         ST_CHAR: begin
            if (rsp_tready) begin
               state_in = at_last ? ST_IDLE : ST_READ;
            end
         end
         ST_LONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      len_in          = len_ff;
      cnt_in          = cnt_ff;
      idx_in          = idx_ff;
      ovf_in          = ovf_ff;
      status_in       = status_ff;
      store_ctl.wr_en = 1'b0;
      store_ctl.rd_en = 1'b0;
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      rsp_tdata       = 8'd0;
      rsp_tuser       = {1'b0, status_ff};
      rsp_tlast       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (is_term) begin
                  if (ovf_ff) begin
                     ovf_in    = 1'b0;
                     len_in    = '0;
                     status_in = STATUS_TOO_LONG;
                  end else if (len_ff != '0) begin
                     len_in    = '0;
                     status_in = STATUS_READY;
                     cnt_in    = n_line;
                     idx_in    = '0;
                  end
               end else if (is_print) begin
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     store_ctl.wr_en = 1'b1;
                     len_in          = len_ff + {{(LW-1){1'b0}}, 1'b1};
                  end
               end
            end
         end
         ST_READ: begin
            store_ctl.rd_en = 1'b1;
         end
         ST_CHAR: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {1'b0, rd_data};
            rsp_tuser  = {1'b1, STATUS_READY};
            rsp_tlast  = at_last;
            if (rsp_tready) begin
               idx_in = idx_ff + {{(LW-1){1'b0}}, 1'b1};
            end
         end
         ST_LONE: begin
            rsp_tvalid = 1'b1;
            rsp_tuser  = {1'b0, status_ff};
            rsp_tlast  = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         max_ff   <= MAX_OUT_LEN_RESET;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   tla_store #(
      .DEPTH (LINE_CAPACITY)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (len_ff),
      .wr_data (req_tdata[6:0]),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

endmodule

// ----- hw/rtl/tla_checker.sv -----
// Port-level checks for the text line assembler, bound to the top level.
// Depends on tla_pkg for the status codes.
`timescale 1ns / 1ps

module tla_checker
   import tla_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a line is being replayed");

   a_too_long: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == STATUS_TOO_LONG) |->
         rsp_tlast && !rsp_tuser[1] && (rsp_tdata == 8'd0))
      else $error("too-long result is not a lone empty item");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tlast)
      else $error("result without a character is not last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind text_line_assembler tla_checker u_chk (.*);
